// File: rtl/dsgd_pkg.sv
package dsgd_pkg;

  // framing symbols
  localparam logic [7:0] SYM_DLE = 8'h10;
  localparam logic [7:0] SYM_ETX = 8'h03;

  // payload limit and counter width (count must reach the limit itself)
  localparam int MAX_PAYLOAD = 64;
  localparam int CNT_W = 7;
  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_PAYLOAD);
  localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(MAX_PAYLOAD - 1);

  // result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ABORT = 2'd2;

  // framer phases
  localparam logic [1:0] PH_HUNT  = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_BODY  = 2'd2;
  localparam logic [1:0] PH_ESC   = 2'd3;

  // packet ids that carry status
  localparam logic [7:0] ID_HEALTH    = 8'h46;
  localparam logic [7:0] ID_POSITION  = 8'h4a;
  localparam logic [7:0] ID_MACHINE   = 8'h4b;
  localparam logic [7:0] ID_SATS      = 8'h6d;
  localparam logic [7:0] ID_BURST_END = 8'h82;

  // fix mode codes in the satellite packet and as reported
  localparam logic [2:0] RAW_MODE_2D = 3'd3;
  localparam logic [2:0] RAW_MODE_3D = 3'd4;
  localparam logic [1:0] FIX_NONE = 2'd0;
  localparam logic [1:0] FIX_2D   = 2'd1;
  localparam logic [1:0] FIX_3D   = 2'd2;

  // operation queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QCNT_W-1:0] QUEUE_ROOM_LIMIT = QCNT_W'(QUEUE_DEPTH - 2);

  typedef struct packed {
    logic [1:0]       kind;
    logic [CNT_W-1:0] position;
    logic [7:0]       data_byte;
    logic [7:0]       packet_id;
    logic [7:0]       first;
    logic [7:0]       second;
  } op_t;

  typedef struct packed {
    logic push0;
    logic push1;
    op_t  op0;
    op_t  op1;
  } push_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [CNT_W-1:0] position;
    logic [7:0]       data_byte;
    logic [7:0]       packet_id;
    logic [7:0]       receiver_status;
    logic [3:0]       health_flags;
    logic [1:0]       fix_mode;
    logic [3:0]       sat_count;
    logic             position_valid;
    logic             sequence_done;
  } result_t;

endpackage

// File: rtl/dsgd_front.sv
module dsgd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         rx_byte,
  output dsgd_pkg::push_t    req
);

  logic [1:0]                 phase, phase_next;
  logic [dsgd_pkg::CNT_W-1:0] count, count_next;
  logic [7:0]                 current_id, current_id_next;
  logic [7:0]                 first, first_next;
  logic [7:0]                 second, second_next;
  logic [7:0]                 keep_val;
  logic [dsgd_pkg::CNT_W-1:0] count_inc;

  function automatic dsgd_pkg::op_t mk_op(input logic [1:0] kind,
                                          input logic [dsgd_pkg::CNT_W-1:0] pos,
                                          input logic [7:0] data,
                                          input logic [7:0] id,
                                          input logic [7:0] b0,
                                          input logic [7:0] b1);
    dsgd_pkg::op_t o;
    o.kind      = kind;
    o.position  = pos;
    o.data_byte = data;
    o.packet_id = id;
    o.first     = b0;
    o.second    = b1;
    return o;
  endfunction

  assign count_inc = count + dsgd_pkg::CNT_W'(1);

  always_comb begin
    phase_next      = phase;
    count_next      = count;
    current_id_next = current_id;
    first_next      = first;
    second_next     = second;
    keep_val        = (phase == dsgd_pkg::PH_BODY) ? rx_byte : dsgd_pkg::SYM_DLE;
    req             = '0;
    case (phase)
      dsgd_pkg::PH_HUNT: begin
        if (rx_byte == dsgd_pkg::SYM_DLE) phase_next = dsgd_pkg::PH_START;
      end
      dsgd_pkg::PH_START: begin
        if (rx_byte != dsgd_pkg::SYM_DLE && rx_byte != dsgd_pkg::SYM_ETX) begin
          current_id_next = rx_byte;
          count_next      = '0;
          first_next      = '0;
          second_next     = '0;
          phase_next      = dsgd_pkg::PH_BODY;
        end else begin
          phase_next = dsgd_pkg::PH_HUNT;
        end
      end
      default: begin
        if (phase == dsgd_pkg::PH_BODY && rx_byte == dsgd_pkg::SYM_DLE) begin
          phase_next = dsgd_pkg::PH_ESC;
        end else if (phase == dsgd_pkg::PH_ESC && rx_byte == dsgd_pkg::SYM_ETX) begin
          // end of packet, decode happens in the back part
          req.push0  = 1'b1;
          req.op0    = mk_op(dsgd_pkg::KIND_DONE, count, 8'h00, current_id, first, second);
          phase_next = dsgd_pkg::PH_HUNT;
        end else if (count >= dsgd_pkg::MAX_COUNT) begin
          // overflow on the first byte to keep
          req.push0  = 1'b1;
          req.op0    = mk_op(dsgd_pkg::KIND_ABORT, dsgd_pkg::MAX_COUNT, 8'h00,
                             current_id, first, second);
          phase_next = dsgd_pkg::PH_HUNT;
        end else begin
          // keep one byte: plain payload, escaped DLE, or the DLE of a lone DLE
          req.push0  = 1'b1;
          req.op0    = mk_op(dsgd_pkg::KIND_BYTE, count, keep_val, current_id, first, second);
          count_next = count_inc;
          phase_next = dsgd_pkg::PH_BODY;
          if (count == '0) first_next = keep_val;
          if (count == dsgd_pkg::CNT_W'(1)) second_next = keep_val;
          if (phase == dsgd_pkg::PH_ESC && rx_byte != dsgd_pkg::SYM_DLE) begin
            // lone DLE: the byte after it is kept too, or the packet aborts if the DLE took the last slot
            req.push1 = 1'b1;
            if (count == dsgd_pkg::LAST_SLOT) begin
              req.op1    = mk_op(dsgd_pkg::KIND_ABORT, dsgd_pkg::MAX_COUNT, 8'h00,
                                 current_id, first, second);
              phase_next = dsgd_pkg::PH_HUNT;
            end else begin
              req.op1    = mk_op(dsgd_pkg::KIND_BYTE, count_inc, rx_byte, current_id,
                                 first, second);
              count_next = count + dsgd_pkg::CNT_W'(2);
              if (count == '0) second_next = rx_byte;
            end
          end
        end
      end
    endcase
    if (!accept) begin
      req.push0 = 1'b0;
      req.push1 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= dsgd_pkg::PH_HUNT;
      count      <= '0;
      current_id <= '0;
      first      <= '0;
      second     <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      count      <= count_next;
      current_id <= current_id_next;
      first      <= first_next;
      second     <= second_next;
    end
  end

endmodule

// File: rtl/dsgd_queue.sv
module dsgd_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  dsgd_pkg::push_t             req,
  output logic                        no_room,
  output logic                        op_valid,
  output dsgd_pkg::op_t               op,
  input  logic                        op_take,
  output logic [dsgd_pkg::QCNT_W-1:0] fill
);

  dsgd_pkg::op_t               mem [dsgd_pkg::QUEUE_DEPTH];
  logic [dsgd_pkg::QPTR_W-1:0] wr_ptr, rd_ptr, wr_ptr1;
  logic [dsgd_pkg::QCNT_W-1:0] n_in, n_out;

  assign wr_ptr1  = wr_ptr + dsgd_pkg::QPTR_W'(1);
  assign op_valid = (fill != '0);
  assign op       = mem[rd_ptr];
  // room for two operations is needed before a byte is taken
  assign no_room  = (fill > dsgd_pkg::QUEUE_ROOM_LIMIT);
  assign n_in     = dsgd_pkg::QCNT_W'(req.push0) + dsgd_pkg::QCNT_W'(req.push1);
  assign n_out    = dsgd_pkg::QCNT_W'(op_take && op_valid);

  always_ff @(posedge clk) begin
    if (req.push0) mem[wr_ptr] <= req.op0;
    if (req.push1) mem[wr_ptr1] <= req.op1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + dsgd_pkg::QPTR_W'(n_in);
      rd_ptr <= rd_ptr + dsgd_pkg::QPTR_W'(n_out);
      fill   <= fill + n_in - n_out;
    end
  end

endmodule

// File: rtl/dsgd_back.sv
module dsgd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              op_valid,
  input  dsgd_pkg::op_t     op,
  output logic              op_take,
  output logic              res_valid,
  output dsgd_pkg::result_t res,
  input  logic              res_pop
);

  logic [7:0] status_byte, status_byte_next;
  logic [3:0] health_bits, health_bits_next;
  logic [1:0] mode_bits, mode_bits_next;
  logic [3:0] sats_seen, sats_seen_next;
  logic       pos_seen, pos_seen_next;
  logic       burst_end, burst_end_next;

  assign op_take = op_valid && (!res_valid || res_pop);

  always_comb begin
    status_byte_next = status_byte;
    health_bits_next = health_bits;
    mode_bits_next   = mode_bits;
    sats_seen_next   = sats_seen;
    pos_seen_next    = pos_seen;
    burst_end_next   = burst_end;
    if (op.kind == dsgd_pkg::KIND_DONE) begin
      case (op.packet_id)
        dsgd_pkg::ID_HEALTH: begin
          status_byte_next    = op.second;
          health_bits_next[0] = op.second[0];
          health_bits_next[1] = op.second[4];
        end
        dsgd_pkg::ID_POSITION: pos_seen_next = 1'b1;
        dsgd_pkg::ID_MACHINE: begin
          health_bits_next[2] = op.second[1];
          health_bits_next[3] = op.second[3];
        end
        dsgd_pkg::ID_SATS: begin
          if (op.first[2:0] == dsgd_pkg::RAW_MODE_2D) mode_bits_next = dsgd_pkg::FIX_2D;
          else if (op.first[2:0] == dsgd_pkg::RAW_MODE_3D) mode_bits_next = dsgd_pkg::FIX_3D;
          else mode_bits_next = dsgd_pkg::FIX_NONE;
          sats_seen_next = op.first[7:4];
        end
        dsgd_pkg::ID_BURST_END: burst_end_next = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid   <= 1'b0;
      status_byte <= '0;
      health_bits <= '0;
      mode_bits   <= '0;
      sats_seen   <= '0;
      pos_seen    <= 1'b0;
      burst_end   <= 1'b0;
    end else if (op_take) begin
      res_valid   <= 1'b1;
      status_byte <= status_byte_next;
      health_bits <= health_bits_next;
      mode_bits   <= mode_bits_next;
      sats_seen   <= sats_seen_next;
      pos_seen    <= pos_seen_next;
      burst_end   <= burst_end_next;
    end else if (res_pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op_take) begin
      res.kind            <= op.kind;
      res.position        <= op.position;
      res.data_byte       <= op.data_byte;
      res.packet_id       <= op.packet_id;
      res.receiver_status <= status_byte_next;
      res.health_flags    <= health_bits_next;
      res.fix_mode        <= mode_bits_next;
      res.sat_count       <= sats_seen_next;
      res.position_valid  <= pos_seen_next;
      res.sequence_done   <= burst_end_next;
    end
  end

endmodule

// File: rtl/dle_stuffed_gps_packet_deframer.sv
// a byte that yields a result passes through the operation queue and the result register to the result ports
// throughput: one byte per cycle while the queue has room; a lone DLE inside a payload yields two results,
//   which leave one per cycle through the single result register while the receiver pops
// byte intake stops while the operation queue lacks room for two operations
// reset (rst, synchronous): framer back to hunting, queue and result register emptied,
//   all status fields cleared
module dle_stuffed_gps_packet_deframer (
  input  logic       clk,
  input  logic       rst,
  // byte input, queue style
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  // result output, queue style
  output logic       empty,
  input  logic       pop,
  output logic [1:0] kind,
  output logic [6:0] position,
  output logic [7:0] data_byte,
  output logic [7:0] packet_id,
  output logic [7:0] receiver_status,
  output logic [3:0] health_flags,
  output logic [1:0] fix_mode,
  output logic [3:0] sat_count,
  output logic       position_valid,
  output logic       sequence_done
);

  // front: framing, un-stuffing, overflow check; up to two operations per byte
  // queue: holds operations so the framer keeps taking bytes while results wait
  // back: status decode and the result register
  dsgd_pkg::push_t                req;
  dsgd_pkg::op_t                  op;
  dsgd_pkg::result_t              res;
  logic                           accept;
  logic                           op_valid;
  logic                           op_take;
  logic                           res_valid;
  logic [dsgd_pkg::QCNT_W-1:0]    fill;

  // a transaction on the input side
  assign accept = push && !full;

  dsgd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .req     (req)
  );

  dsgd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .no_room  (full),
    .op_valid (op_valid),
    .op       (op),
    .op_take  (op_take),
    .fill     (fill)
  );

  dsgd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op        (op),
    .op_take   (op_take),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (pop)
  );

  // result ports straight from the result register
  assign empty           = !res_valid;
  assign kind            = res.kind;
  assign position        = res.position;
  assign data_byte       = res.data_byte;
  assign packet_id       = res.packet_id;
  assign receiver_status = res.receiver_status;
  assign health_flags    = res.health_flags;
  assign fix_mode        = res.fix_mode;
  assign sat_count       = res.sat_count;
  assign position_valid  = res.position_valid;
  assign sequence_done   = res.sequence_done;

  // queue never holds more operations than it has slots
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= dsgd_pkg::QCNT_W'(dsgd_pkg::QUEUE_DEPTH))
    else $error("operation queue overfilled");

  // a second operation is only pushed together with a first
  a_push_pair: assert property (@(posedge clk) disable iff (rst)
    req.push1 |-> req.push0)
    else $error("second operation without first");

  // nothing is pushed unless a byte transaction happens
  a_push_on_accept: assert property (@(posedge clk) disable iff (rst)
    (req.push0 || req.push1) |-> accept)
    else $error("operation pushed without a byte");

  // last result taken with nothing queued leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !op_valid) |=> empty)
    else $error("result register refilled from an empty queue");

  // status flags that latch once set never clear outside reset
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    (!empty && position_valid && sequence_done) |=>
      (empty || (position_valid && sequence_done)))
    else $error("sticky status flag cleared");

endmodule

// File: test/gps_deframe_checker.sv
module gps_deframe_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] rx_byte,
  input  logic       empty,
  input  logic       pop,
  input  logic [1:0] kind,
  input  logic [6:0] position,
  input  logic [7:0] data_byte,
  input  logic [7:0] packet_id,
  input  logic [7:0] receiver_status,
  input  logic [3:0] health_flags,
  input  logic [1:0] fix_mode,
  input  logic [3:0] sat_count,
  input  logic       position_valid,
  input  logic       sequence_done,
  output int         errors,
  output int         outstanding
);

  // predicted deframer state
  logic [1:0]                 phase;
  logic [dsgd_pkg::CNT_W-1:0] pay_count;
  logic [7:0]                 cur_id;
  logic [7:0]                 pay0;
  logic [7:0]                 pay1;
  logic [7:0]                 status;
  logic [3:0]                 health;
  logic [1:0]                 mode;
  logic [3:0]                 sats;
  logic                       pos_seen;
  logic                       burst_end;

  dsgd_pkg::result_t pending_reports[$];

  task automatic queue_report(input logic [1:0] k, input logic [dsgd_pkg::CNT_W-1:0] pos,
                              input logic [7:0] data);
    dsgd_pkg::result_t r;
    r.kind            = k;
    r.position        = pos;
    r.data_byte       = data;
    r.packet_id       = cur_id;
    r.receiver_status = status;
    r.health_flags    = health;
    r.fix_mode        = mode;
    r.sat_count       = sats;
    r.position_valid  = pos_seen;
    r.sequence_done   = burst_end;
    pending_reports.push_back(r);
  endtask

  // keep one payload byte, abort the packet when it has no room left
  task automatic keep_payload(input logic [7:0] b, output bit kept);
    if (pay_count >= dsgd_pkg::MAX_COUNT) begin
      queue_report(dsgd_pkg::KIND_ABORT, dsgd_pkg::MAX_COUNT, 8'h00);
      phase = dsgd_pkg::PH_HUNT;
      kept = 1'b0;
    end else begin
      if (pay_count == '0) pay0 = b;
      else if (pay_count == dsgd_pkg::CNT_W'(1)) pay1 = b;
      queue_report(dsgd_pkg::KIND_BYTE, pay_count, b);
      pay_count = pay_count + dsgd_pkg::CNT_W'(1);
      kept = 1'b1;
    end
  endtask

  task automatic decode_status();
    case (cur_id)
      dsgd_pkg::ID_HEALTH: begin
        status = pay1;
        health = {health[3:2], pay1[4], pay1[0]};
      end
      dsgd_pkg::ID_POSITION: pos_seen = 1'b1;
      dsgd_pkg::ID_MACHINE: health = {pay1[3], pay1[1], health[1:0]};
      dsgd_pkg::ID_SATS: begin
        case (pay0[2:0])
          dsgd_pkg::RAW_MODE_2D: mode = dsgd_pkg::FIX_2D;
          dsgd_pkg::RAW_MODE_3D: mode = dsgd_pkg::FIX_3D;
          default: mode = dsgd_pkg::FIX_NONE;
        endcase
        sats = pay0[7:4];
      end
      dsgd_pkg::ID_BURST_END: burst_end = 1'b1;
      default: ;
    endcase
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    bit kept;
    case (phase)
      dsgd_pkg::PH_HUNT: if (b == dsgd_pkg::SYM_DLE) phase = dsgd_pkg::PH_START;
      dsgd_pkg::PH_START: begin
        if (b != dsgd_pkg::SYM_DLE && b != dsgd_pkg::SYM_ETX) begin
          cur_id = b;
          pay_count = '0;
          pay0 = 8'h00;
          pay1 = 8'h00;
          phase = dsgd_pkg::PH_BODY;
        end else begin
          phase = dsgd_pkg::PH_HUNT;
        end
      end
      dsgd_pkg::PH_BODY: begin
        if (b == dsgd_pkg::SYM_DLE) phase = dsgd_pkg::PH_ESC;
        else keep_payload(b, kept);
      end
      default: begin
        if (b == dsgd_pkg::SYM_DLE) begin
          phase = dsgd_pkg::PH_BODY;
          keep_payload(dsgd_pkg::SYM_DLE, kept);
        end else if (b == dsgd_pkg::SYM_ETX) begin
          decode_status();
          queue_report(dsgd_pkg::KIND_DONE, pay_count, 8'h00);
          phase = dsgd_pkg::PH_HUNT;
        end else begin
          // lone dle keeps both bytes
          phase = dsgd_pkg::PH_BODY;
          keep_payload(dsgd_pkg::SYM_DLE, kept);
          if (kept) keep_payload(b, kept);
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors = errors + 1;
    end
  endtask

  always @(posedge clk) begin
    dsgd_pkg::result_t want;
    if (rst) begin
      phase = dsgd_pkg::PH_HUNT;
      pay_count = '0;
      cur_id = 8'h00;
      pay0 = 8'h00;
      pay1 = 8'h00;
      status = 8'h00;
      health = 4'h0;
      mode = dsgd_pkg::FIX_NONE;
      sats = 4'h0;
      pos_seen = 1'b0;
      burst_end = 1'b0;
      pending_reports.delete();
      errors = 0;
    end else begin
      if (pop && !empty) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: unexpected result, kind %0h position %0h data %0h",
                   $time, kind, position, data_byte);
          errors = errors + 1;
        end else begin
          want = pending_reports.pop_front();
          check_field("kind", 8'(want.kind), 8'(kind));
          check_field("position", 8'(want.position), 8'(position));
          check_field("data_byte", want.data_byte, data_byte);
          check_field("packet_id", want.packet_id, packet_id);
          check_field("receiver_status", want.receiver_status, receiver_status);
          check_field("health_flags", 8'(want.health_flags), 8'(health_flags));
          check_field("fix_mode", 8'(want.fix_mode), 8'(fix_mode));
          check_field("sat_count", 8'(want.sat_count), 8'(sat_count));
          check_field("position_valid", 8'(want.position_valid), 8'(position_valid));
          check_field("sequence_done", 8'(want.sequence_done), 8'(sequence_done));
        end
      end
      if (push && !full) deframe_byte(rx_byte);
    end
    outstanding = pending_reports.size();
  end

endmodule

// File: test/tb_dle_stuffed_gps_packet_deframer.sv
module tb_dle_stuffed_gps_packet_deframer;

  localparam int RANDOM_ITEMS = 1250;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_EVERY  = 500;
  localparam int TAIL_CYCLES  = 20;

  logic       clk = 1'b0;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] rx_byte;
  logic       empty;
  logic       pop;
  logic [1:0] kind;
  logic [6:0] position;
  logic [7:0] data_byte;
  logic [7:0] packet_id;
  logic [7:0] receiver_status;
  logic [3:0] health_flags;
  logic [1:0] fix_mode;
  logic [3:0] sat_count;
  logic       position_valid;
  logic       sequence_done;

  int errors;
  int outstanding;

  // sender pacing: bursts of back-to-back transactions alternate with gappy stretches
  int tx_count;
  int tx_burst_left = 0;
  bit tx_quiet = 1'b0;
  // receiver pacing, plus a one-shot request for a long hold-off
  int rx_burst_left = 0;
  bit rx_quiet = 1'b0;
  bit long_hold = 1'b0;

  // logical payload of the next frame; bit 8 marks a lone dle ahead of the byte
  logic [8:0] frame_body[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  dle_stuffed_gps_packet_deframer i_dut (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .rx_byte         (rx_byte),
    .empty           (empty),
    .pop             (pop),
    .kind            (kind),
    .position        (position),
    .data_byte       (data_byte),
    .packet_id       (packet_id),
    .receiver_status (receiver_status),
    .health_flags    (health_flags),
    .fix_mode        (fix_mode),
    .sat_count       (sat_count),
    .position_valid  (position_valid),
    .sequence_done   (sequence_done)
  );

  gps_deframe_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .rx_byte         (rx_byte),
    .empty           (empty),
    .pop             (pop),
    .kind            (kind),
    .position        (position),
    .data_byte       (data_byte),
    .packet_id       (packet_id),
    .receiver_status (receiver_status),
    .health_flags    (health_flags),
    .fix_mode        (fix_mode),
    .sat_count       (sat_count),
    .position_valid  (position_valid),
    .sequence_done   (sequence_done),
    .errors          (errors),
    .outstanding     (outstanding)
  );

  // one byte transaction; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (tx_burst_left == 0) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      tx_burst_left = $urandom_range(10, 60);
    end
    tx_burst_left--;
    gap = tx_quiet ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    rx_byte <= b;
    // hold the byte until the block takes it
    do @(posedge clk); while (full);
    @(negedge clk);
    tx_count++;
  endtask

  // dle, id, stuffed payload and, if close is set, dle etx
  task automatic send_frame(input logic [7:0] id, input bit close);
    send_byte(dsgd_pkg::SYM_DLE);
    send_byte(id);
    foreach (frame_body[i]) begin
      if (frame_body[i][8] || frame_body[i][7:0] == dsgd_pkg::SYM_DLE)
        send_byte(dsgd_pkg::SYM_DLE);
      send_byte(frame_body[i][7:0]);
    end
    if (close) begin
      send_byte(dsgd_pkg::SYM_DLE);
      send_byte(dsgd_pkg::SYM_ETX);
    end
    frame_body.delete();
  endtask

  task automatic send_random_frame(input int len, input bit close);
    logic [7:0] id;
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0: id = dsgd_pkg::ID_HEALTH;
      1: id = dsgd_pkg::ID_POSITION;
      2: id = dsgd_pkg::ID_MACHINE;
      3: id = dsgd_pkg::ID_SATS;
      4: id = dsgd_pkg::ID_BURST_END;
      5: begin
        // occasionally a bad start
        if ($urandom_range(0, 1) == 0)
          id = $urandom_range(0, 1) ? dsgd_pkg::SYM_DLE : dsgd_pkg::SYM_ETX;
        else id = dsgd_pkg::ID_SATS;
      end
      default: begin
        do id = 8'($urandom_range(0, 255));
        while (id == dsgd_pkg::SYM_DLE || id == dsgd_pkg::SYM_ETX);
      end
    endcase
    repeat (len) begin
      b = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 15))
        0, 1: frame_body.push_back({1'b0, dsgd_pkg::SYM_DLE});
        2: frame_body.push_back({1'b0, dsgd_pkg::SYM_ETX});
        3: begin
          // lone dle needs a follower other than dle and etx
          if (b == dsgd_pkg::SYM_DLE || b == dsgd_pkg::SYM_ETX) b = 8'h55;
          frame_body.push_back({1'b1, b});
        end
        default: frame_body.push_back({1'b0, b});
      endcase
    end
    send_frame(id, close);
  endtask

  // receiver: random pop gaps, quiet stretches, and the long hold-off on request
  initial begin
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      int wait_cycles;
      if (long_hold) begin
        long_hold = 1'b0;
        wait_cycles = HOLD_CYCLES;
      end else begin
        if (rx_burst_left == 0) begin
          rx_quiet = ($urandom_range(0, 3) == 0);
          rx_burst_left = $urandom_range(10, 60);
        end
        rx_burst_left--;
        wait_cycles = rx_quiet ? 0 : $urandom_range(0, 6);
      end
      if (wait_cycles != 0) begin
        pop <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      @(negedge clk);
    end
  end

  // watchdog
  initial begin
    #4800000;
    $display("tb_dle_stuffed_gps_packet_deframer: errors");
    $finish;
  end

  initial begin
    int next_drain;
    int len;
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    rx_byte = 8'h00;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: line noise while hunting
    send_byte(8'h00);
    send_byte(8'hff);
    // bad start with dle dle, then with dle etx
    send_byte(dsgd_pkg::SYM_DLE);
    send_byte(dsgd_pkg::SYM_DLE);
    send_byte(dsgd_pkg::SYM_DLE);
    send_byte(dsgd_pkg::SYM_ETX);
    // health packet with a stuffed dle in the payload
    frame_body = '{9'h000, 9'h011, {1'b0, dsgd_pkg::SYM_DLE}, 9'h0ff};
    send_frame(dsgd_pkg::ID_HEALTH, 1'b1);
    // empty position packet
    send_frame(dsgd_pkg::ID_POSITION, 1'b1);
    frame_body = '{9'h0ff, 9'h00a};
    send_frame(dsgd_pkg::ID_MACHINE, 1'b1);
    // satellite packet: 2d fix, 3d fix, no fix
    frame_body = '{9'h0f3};
    send_frame(dsgd_pkg::ID_SATS, 1'b1);
    frame_body = '{9'h054};
    send_frame(dsgd_pkg::ID_SATS, 1'b1);
    frame_body = '{9'h007};
    send_frame(dsgd_pkg::ID_SATS, 1'b1);
    send_frame(dsgd_pkg::ID_BURST_END, 1'b1);
    // lone dle and a raw etx as payload, unknown id
    frame_body = '{9'h001, 9'h155, {1'b0, dsgd_pkg::SYM_ETX}};
    send_frame(8'hff, 1'b1);
    // short health packet: second payload byte reads as zero
    frame_body = '{9'h0ff};
    send_frame(dsgd_pkg::ID_HEALTH, 1'b1);
    send_frame(8'h00, 1'b1);
    // overflow by a plain byte
    repeat (dsgd_pkg::MAX_PAYLOAD + 1)
      frame_body.push_back(9'($urandom_range(0, 255) & 9'h0ef));
    send_frame(8'h21, 1'b1);
    // lone dle fills the last slot, its follower overflows
    repeat (dsgd_pkg::MAX_PAYLOAD - 1) frame_body.push_back(9'h020);
    frame_body.push_back(9'h1a5);
    send_frame(8'h22, 1'b1);
    // stuffed dle at the limit
    repeat (dsgd_pkg::MAX_PAYLOAD) frame_body.push_back(9'h0e1);
    frame_body.push_back({1'b0, dsgd_pkg::SYM_DLE});
    send_frame(8'h23, 1'b1);
    // lone dle at the limit
    repeat (dsgd_pkg::MAX_PAYLOAD) frame_body.push_back(9'h07e);
    frame_body.push_back(9'h1c3);
    send_frame(8'h24, 1'b1);

    // random frames with some line noise in between
    tx_count = 0;
    next_drain = DRAIN_EVERY;
    while (tx_count < RANDOM_ITEMS) begin
      if (tx_count >= next_drain) begin
        // pause until every expected transaction has come out
        push <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        // then hold the receiver off and stream a long frame into a full block
        long_hold = 1'b1;
        tx_quiet = 1'b1;
        tx_burst_left = 80;
        send_random_frame(40, 1'b1);
        next_drain += DRAIN_EVERY;
      end
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      case ($urandom_range(0, 19))
        0: len = $urandom_range(60, 68);
        1, 2: len = $urandom_range(11, 40);
        default: len = $urandom_range(0, 10);
      endcase
      send_random_frame(len, $urandom_range(0, 9) != 0);
    end

    push <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0)
      $display("tb_dle_stuffed_gps_packet_deframer: clean");
    else
      $display("tb_dle_stuffed_gps_packet_deframer: errors");
    $finish;
  end

endmodule

// File: dle_stuffed_gps_packet_deframer.f
rtl/dsgd_pkg.sv
rtl/dsgd_front.sv
rtl/dsgd_queue.sv
rtl/dsgd_back.sv
rtl/dle_stuffed_gps_packet_deframer.sv
test/gps_deframe_checker.sv
test/tb_dle_stuffed_gps_packet_deframer.sv
